// ----- design/belt_soft_start_stop_sequencer_macros.svh -----
// Assertion macros shared by the belt sequencer RTL.
`ifndef BELT_SOFT_START_STOP_SEQUENCER_MACROS_SVH
`define BELT_SOFT_START_STOP_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BSSS_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define BSSS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/bsss_pkg.sv -----
// Types and constants for the belt soft start/stop sequencer.
package bsss_pkg;

   localparam int unsigned CNT_W  = 16;
   localparam int unsigned STEP_W = 4;
   localparam int unsigned SPD_W  = 3;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [STEP_W-1:0] STEP_TOP = 4'd8;

   // item kinds carried in tuser
   localparam logic CMD_SENSOR = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_DWELL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_DWELL  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_DELAY  = 2'd2;

   localparam logic [CNT_W-1:0] START_DWELL_RST = 16'd400;
   localparam logic [CNT_W-1:0] STOP_DWELL_RST  = 16'd400;
   localparam logic [CNT_W-1:0] STOP_DELAY_RST  = 16'd200;

   typedef struct packed {
      logic [CNT_W-1:0] start_dwell;
      logic [CNT_W-1:0] stop_dwell;
      logic [CNT_W-1:0] stop_delay;
   } cfg_type;

   typedef struct packed {
      logic [STEP_W-1:0] step;
      logic [SPD_W-1:0]  speed;
      logic              up_flag;
      logic              down_flag;
      logic              up_done;
      logic              delay_done;
      logic              delay_flag;
      logic [CNT_W-1:0]  up_count;
      logic [CNT_W-1:0]  down_count;
      logic [CNT_W-1:0]  delay_count;
   } state_type;

   typedef struct packed {
      logic              delay_active;
      logic              ramping_down;
      logic              ramping_up;
      logic              start_complete;
      logic [STEP_W-1:0] ramp_step;
      logic [SPD_W-1:0]  speed_code;
   } result_type;

   localparam int unsigned RESULT_W = $bits(result_type);

endpackage

// ----- design/bsss_step.sv -----
// Next-state and result logic for one sensor or tick item.
module bsss_step (
   input  bsss_pkg::cfg_type    cfg,
   input  bsss_pkg::state_type  cur,
   input  logic                 command,
   input  logic                 sensor_blocked,
   output bsss_pkg::state_type  nxt,
   output bsss_pkg::result_type result
);

   always_comb begin
      logic [bsss_pkg::CNT_W-1:0] limit_up;
      logic [bsss_pkg::CNT_W-1:0] limit_dn;
      logic [bsss_pkg::CNT_W-1:0] up_inc;
      logic [bsss_pkg::CNT_W-1:0] dn_inc;
      logic [bsss_pkg::CNT_W-1:0] dly_inc;

      nxt = cur;
      limit_up = '0;
      limit_dn = '0;
      up_inc = '0;
      dn_inc = '0;
      dly_inc = '0;

      if (command == bsss_pkg::CMD_SENSOR) begin
         if (sensor_blocked) begin
            if (!cur.up_flag) begin
               nxt.up_flag    = 1'b1;
               nxt.down_flag  = 1'b0;
               nxt.up_done    = 1'b0;
               nxt.delay_done = 1'b0;
               nxt.delay_flag = 1'b0;
               if (cur.step != '0) begin
                  nxt.step = cur.step - 4'd1;
               end
            end
         end else begin
            if (cur.up_done) begin
               nxt.delay_flag = 1'b1;
               nxt.up_done    = 1'b0;
               nxt.up_flag    = 1'b0;
            end
            if (cur.delay_done) begin
               nxt.down_flag  = 1'b1;
               nxt.up_flag    = 1'b0;
               nxt.delay_done = 1'b0;
            end
         end
      end else begin
         // start ramp first
         if (cur.up_flag) begin
            if (cur.step == '0) begin
               nxt.speed = '0;
               nxt.step  = 4'd1;
            end else if (cur.step > 4'd7) begin
               nxt.up_count = '0;
            end else begin
               nxt.speed = (cur.step == 4'd7) ? 3'd6 : cur.step[bsss_pkg::SPD_W-1:0];
               limit_up = (cur.step == 4'd5) ? cfg.start_dwell
                                             : (cfg.start_dwell >> 2);
               up_inc = cur.up_count + 16'd1;
               nxt.up_count = up_inc;
               if (up_inc >= limit_up) begin
                  if (cur.step == 4'd7) begin
                     nxt.up_done = 1'b1;
                  end
                  nxt.step     = cur.step + 4'd1;
                  nxt.up_count = '0;
               end
            end
         end
         // stop ramp works on the step the start ramp left
         if (cur.down_flag) begin
            if (nxt.step == '0 || nxt.step > bsss_pkg::STEP_TOP) begin
               nxt.speed      = '0;
               nxt.down_count = '0;
            end else if (nxt.step == 4'd1) begin
               nxt.speed      = '0;
               nxt.step       = '0;
               nxt.down_count = '0;
               nxt.up_done    = 1'b0;
            end else begin
               nxt.speed = (nxt.step == bsss_pkg::STEP_TOP) ? 3'd6
                         : 3'(nxt.step - 4'd1);
               limit_dn = (nxt.step <= 4'd3) ? (cfg.stop_dwell >> 2)
                                             : (cfg.stop_dwell >> 1);
               dn_inc = cur.down_count + 16'd1;
               nxt.down_count = dn_inc;
               if (dn_inc >= limit_dn) begin
                  nxt.step       = nxt.step - 4'd1;
                  nxt.down_count = '0;
               end
            end
         end
         if (cur.delay_flag) begin
            dly_inc = cur.delay_count + 16'd1;
            nxt.delay_count = dly_inc;
            if (dly_inc >= cfg.stop_delay) begin
               nxt.delay_done  = 1'b1;
               nxt.delay_flag  = 1'b0;
               nxt.delay_count = '0;
            end
         end
      end
   end

   always_comb begin
      result.speed_code     = nxt.speed;
      result.ramp_step      = nxt.step;
      result.start_complete = nxt.up_done;
      result.ramping_up     = nxt.up_flag;
      result.ramping_down   = nxt.down_flag;
      result.delay_active   = nxt.delay_flag;
   end

endmodule

// ----- design/belt_soft_start_stop_sequencer.sv -----
// Top level of the belt soft start/stop sequencer: item pipeline, state and registers.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_tvalid/req_tready  | tuser: command; tdata: sensor_blocked
//   rsp     | out       | rsp_tvalid/rsp_tready  | tdata: result fields
//   csr     | in        | csr_we                 | csr_index, csr_wdata
//
// One item per cycle sustained while rsp_tready takes each result; each result passes the
// input register, then the result register; the state updates with the result register.
// Reset (synchronous) clears the pipeline and the sequencer state and loads the
// register defaults 400, 400 and 200.
// A stalled result holds both stages; req_tready drops only when both are full.
`include "belt_soft_start_stop_sequencer_macros.svh"

module belt_soft_start_stop_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] sensor_blocked, [7:1] zero
   input  logic [0:0]  req_tuser,   // [0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] speed_code, [6:3] ramp_step, [7] start_complete, [8] ramping_up,
   // [9] ramping_down, [10] delay_active, [15:11] zero
   output logic [15:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   bsss_pkg::cfg_type    cfg_ff;
   bsss_pkg::state_type  state_ff;
   bsss_pkg::state_type  state_in;
   bsss_pkg::result_type result_in;
   bsss_pkg::result_type result_ff;

   logic in_vld_ff;
   logic cmd_ff;
   logic blk_ff;
   logic out_vld_ff;
   logic advance;

   assign advance    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_dwell <= bsss_pkg::START_DWELL_RST;
         cfg_ff.stop_dwell  <= bsss_pkg::STOP_DWELL_RST;
         cfg_ff.stop_delay  <= bsss_pkg::STOP_DELAY_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            bsss_pkg::CSR_START_DWELL: cfg_ff.start_dwell <= csr_wdata;
            bsss_pkg::CSR_STOP_DWELL:  cfg_ff.stop_dwell  <= csr_wdata;
            bsss_pkg::CSR_STOP_DELAY:  cfg_ff.stop_delay  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         cmd_ff <= req_tuser[0];
         blk_ff <= req_tdata[0];
      end
   end

   bsss_step u_step (
      .cfg            (cfg_ff),
      .cur            (state_ff),
      .command        (cmd_ff),
      .sensor_blocked (blk_ff),
      .nxt            (state_in),
      .result         (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {5'd0, result_ff};

   `BSSS_ASSERT_SAME(a_ramps_exclusive, clock, reset, 1'b1, !(state_ff.up_flag && state_ff.down_flag), "start and stop ramps armed together")
   `BSSS_ASSERT_SAME(a_step_range, clock, reset, 1'b1, state_ff.step <= bsss_pkg::STEP_TOP, "ramp step beyond top")
   `BSSS_ASSERT_NEXT(a_advance_result, clock, reset, advance, out_vld_ff, "item advanced without a result")

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the belt sequencer: stream driver, monitor, predictor.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // speed driven at step 7 going up, 8 going down
   localparam logic [bsss_pkg::SPD_W-1:0] SPEED_CAP = 3'd6;
   localparam int unsigned SEG_MAX = 200;

   typedef struct packed {
      logic cmd;
      logic blocked;
   } belt_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;    // [0] sensor_blocked, [7:1] zero
   logic [0:0]  req_tuser = 1'b0;    // [0] command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;           // result_type fields, speed_code in the lowest bits
   logic        csr_we = 1'b0;
   logic [bsss_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [15:0] csr_wdata = 16'd0;

   belt_soft_start_stop_sequencer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // predicted sequencer state and registers
   logic [bsss_pkg::CNT_W-1:0]  cfg_start = bsss_pkg::START_DWELL_RST;
   logic [bsss_pkg::CNT_W-1:0]  cfg_stop  = bsss_pkg::STOP_DWELL_RST;
   logic [bsss_pkg::CNT_W-1:0]  cfg_delay = bsss_pkg::STOP_DELAY_RST;
   logic [bsss_pkg::STEP_W-1:0] st_step = '0;
   logic [bsss_pkg::SPD_W-1:0]  st_speed = '0;
   logic                        st_rising = 1'b0;
   logic                        st_falling = 1'b0;
   logic                        st_started = 1'b0;
   logic                        st_delay_over = 1'b0;
   logic                        st_delaying = 1'b0;
   logic [bsss_pkg::CNT_W-1:0]  rise_cnt = '0;
   logic [bsss_pkg::CNT_W-1:0]  fall_cnt = '0;
   logic [bsss_pkg::CNT_W-1:0]  delay_cnt = '0;

   belt_item_type         belt_items[$];
   bsss_pkg::result_type  expected_drive[$];
   int unsigned items_made = 0;
   int unsigned fail_count = 0;
   int unsigned send_gap = 0;
   int unsigned recv_stall = 0;
   int unsigned send_calm = 0;
   int unsigned recv_calm = 0;

   function automatic bsss_pkg::result_type belt_next(input logic cmd, input logic blocked);
      logic [bsss_pkg::CNT_W-1:0]  limit;
      logic [bsss_pkg::STEP_W-1:0] step_less;
      bsss_pkg::result_type        r;
      if (cmd == bsss_pkg::CMD_SENSOR) begin
         if (blocked) begin
            if (!st_rising) begin
               st_rising     = 1'b1;
               st_falling    = 1'b0;
               st_started    = 1'b0;
               st_delay_over = 1'b0;
               st_delaying   = 1'b0;
               if (st_step != 0) st_step = st_step - 4'd1;
            end
         end else begin
            if (st_started) begin
               st_delaying = 1'b1;
               st_started  = 1'b0;
               st_rising   = 1'b0;
            end
            if (st_delay_over) begin
               st_falling    = 1'b1;
               st_rising     = 1'b0;
               st_delay_over = 1'b0;
            end
         end
      end else begin
         // start ramp first, then stop ramp on the step it left, then the delay
         if (st_rising) begin
            if (st_step == 0) begin
               st_speed = '0;
               st_step  = 4'd1;
            end else if (st_step > 4'd7) begin
               rise_cnt = '0;
            end else begin
               st_speed = (st_step == 4'd7) ? SPEED_CAP : st_step[bsss_pkg::SPD_W-1:0];
               limit    = (st_step == 4'd5) ? cfg_start : (cfg_start >> 2);
               rise_cnt = rise_cnt + 16'd1;
               if (rise_cnt >= limit) begin
                  if (st_step == 4'd7) st_started = 1'b1;
                  st_step  = st_step + 4'd1;
                  rise_cnt = '0;
               end
            end
         end
         if (st_falling) begin
            if (st_step == 0 || st_step > bsss_pkg::STEP_TOP) begin
               st_speed = '0;
               fall_cnt = '0;
            end else if (st_step == 4'd1) begin
               st_speed   = '0;
               st_step    = '0;
               fall_cnt   = '0;
               st_started = 1'b0;
            end else begin
               step_less = st_step - 4'd1;
               st_speed  = (st_step == bsss_pkg::STEP_TOP) ? SPEED_CAP
                                                          : step_less[bsss_pkg::SPD_W-1:0];
               limit     = (st_step <= 4'd3) ? (cfg_stop >> 2) : (cfg_stop >> 1);
               fall_cnt  = fall_cnt + 16'd1;
               if (fall_cnt >= limit) begin
                  st_step  = step_less;
                  fall_cnt = '0;
               end
            end
         end
         if (st_delaying) begin
            delay_cnt = delay_cnt + 16'd1;
            if (delay_cnt >= cfg_delay) begin
               st_delay_over = 1'b1;
               st_delaying   = 1'b0;
               delay_cnt     = '0;
            end
         end
      end
      r.speed_code     = st_speed;
      r.ramp_step      = st_step;
      r.start_complete = st_started;
      r.ramping_up     = st_rising;
      r.ramping_down   = st_falling;
      r.delay_active   = st_delaying;
      return r;
   endfunction

   // mostly short gaps, a few long ones, and now and then a run with none
   function automatic int unsigned pick_gap(inout int unsigned calm_left);
      int unsigned r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm_left = $urandom_range(20, 80);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   // driver
   always @(posedge clock) begin
      logic          next_valid;
      belt_item_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         next_valid = req_tvalid && !req_tready;
         if (req_tvalid && req_tready)
            expected_drive.push_back(belt_next(req_tuser[0], req_tdata[0]));
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (belt_items.size() > 0) begin
               it = belt_items.pop_front();
               req_tuser  <= it.cmd;
               req_tdata  <= {7'd0, it.blocked};
               next_valid = 1'b1;
               send_gap   = pick_gap(send_calm);
            end
         end
         req_tvalid <= next_valid;
      end
   end

   // monitor
   always @(posedge clock) begin
      bsss_pkg::result_type got;
      bsss_pkg::result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = bsss_pkg::result_type'(rsp_tdata[bsss_pkg::RESULT_W-1:0]);
            if (expected_drive.size() == 0) begin
               $display("%0t: result with nothing expected, expected none, got %h", $time,
                        rsp_tdata);
               fail_count++;
            end else begin
               want = expected_drive.pop_front();
               check_field("speed_code", want.speed_code, got.speed_code);
               check_field("ramp_step", want.ramp_step, got.ramp_step);
               check_field("start_complete", want.start_complete, got.start_complete);
               check_field("ramping_up", want.ramping_up, got.ramping_up);
               check_field("ramping_down", want.ramping_down, got.ramping_down);
               check_field("delay_active", want.delay_active, got.delay_active);
            end
            recv_stall = pick_gap(recv_calm);
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic push_item(input logic cmd, input logic blocked);
      belt_item_type it;
      it.cmd     = cmd;
      it.blocked = blocked;
      belt_items.push_back(it);
      items_made++;
   endtask

   task automatic push_ticks(input int unsigned n);
      repeat (n) push_item(bsss_pkg::CMD_TICK, 1'($urandom_range(0, 1)));
   endtask

   task automatic push_noise();
      repeat ($urandom_range(1, 6))
         push_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (belt_items.size() != 0 || req_tvalid || expected_drive.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [bsss_pkg::CSR_IDX_W-1:0] idx,
                            input logic [15:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         bsss_pkg::CSR_START_DWELL: cfg_start = val;
         bsss_pkg::CSR_STOP_DWELL:  cfg_stop  = val;
         bsss_pkg::CSR_STOP_DELAY:  cfg_delay = val;
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [15:0] t_start, input logic [15:0] t_stop,
                            input logic [15:0] t_delay);
      write_csr(bsss_pkg::CSR_START_DWELL, t_start);
      write_csr(bsss_pkg::CSR_STOP_DWELL, t_stop);
      write_csr(bsss_pkg::CSR_STOP_DELAY, t_delay);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic int unsigned at_least1(input int unsigned v);
      return (v == 0) ? 1 : v;
   endfunction

   function automatic int unsigned cap_seg(input int unsigned v);
      return (v > SEG_MAX) ? SEG_MAX : v;
   endfunction

   // tick count for one ramp segment: usually enough to finish, sometimes cut short
   function automatic int unsigned seg_len(input int unsigned need);
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, need);
      return need + $urandom_range(0, 3);
   endfunction

   initial begin
      int unsigned mode;
      int unsigned phase;
      int unsigned phase_start;
      int unsigned target;
      int unsigned need_start;
      int unsigned need_delay;
      int unsigned need_stop;
      logic        wide;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // defaults: idle clear sensor, arm, blocked while ramping up, a couple of ticks
      push_item(bsss_pkg::CMD_SENSOR, 1'b0);
      push_item(bsss_pkg::CMD_SENSOR, 1'b1);
      push_item(bsss_pkg::CMD_SENSOR, 1'b1);
      push_item(bsss_pkg::CMD_TICK, 1'b0);
      push_item(bsss_pkg::CMD_TICK, 1'b1);
      wait_idle();

      // zero dwell everywhere: every step advances on the next tick, mid-dwell change too
      write_all(16'd0, 16'd0, 16'd0);
      push_ticks(9);
      push_item(bsss_pkg::CMD_SENSOR, 1'b0);
      push_item(bsss_pkg::CMD_TICK, 1'b0);
      push_item(bsss_pkg::CMD_SENSOR, 1'b0);
      push_ticks(9);
      wait_idle();

      phase = 0;
      while (items_made < 1250) begin
         mode = (phase == 0) ? 1 : $urandom_range(0, 11);
         case (mode)
            0: write_all(16'd0, 16'd0, 16'd0);
            1: write_all(16'hFFFF, 16'hFFFF, 16'hFFFF);
            2: write_all(bsss_pkg::START_DWELL_RST, bsss_pkg::STOP_DWELL_RST,
                         bsss_pkg::STOP_DELAY_RST);
            default: write_all(16'($urandom_range(0, 24)), 16'($urandom_range(0, 24)),
                               16'($urandom_range(0, 12)));
         endcase
         wide = (cfg_start > 16'd1000) && (cfg_stop > 16'd1000);
         need_start = cap_seg(1 + 6 * at_least1(cfg_start >> 2) + at_least1(cfg_start));
         need_delay = cap_seg(at_least1(cfg_delay));
         need_stop  = cap_seg(2 * at_least1(cfg_stop >> 2) + 5 * at_least1(cfg_stop >> 1) + 2);
         target = wide ? 30 : $urandom_range(80, 160);
         phase_start = items_made;
         while (items_made - phase_start < target) begin
            if (wide || $urandom_range(0, 4) == 0) begin
               push_noise();
            end else begin
               push_item(bsss_pkg::CMD_SENSOR, 1'b1);
               push_ticks(seg_len(need_start));
               push_item(bsss_pkg::CMD_SENSOR, 1'b0);
               push_ticks(seg_len(need_delay));
               push_item(bsss_pkg::CMD_SENSOR, 1'b0);
               push_ticks(seg_len(need_stop));
            end
         end
         wait_idle();
         phase++;
      end

      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #(20_000_000);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
